/* hw/rtl/akx_pkg.sv */
// akx_pkg: shared constants and GF(2^8) helpers for the AES-128 key schedule
// holds the S-box table, xtime and the InvMixColumns column function
// no dependencies
`default_nettype none

package akx_pkg;

	localparam int unsigned NUM_ROUNDS = 11;
	localparam logic [3:0] LAST_ROUND = 4'd10;
	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] GF_POLY = 8'h1b;

	// byte 0 sits in the top bits of the packed table
	localparam logic [0:255][7:0] SBOX_TABLE = {
		128'h637c777bf26b6fc53001672bfed7ab76,
		128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115,
		128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84,
		128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8,
		128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973,
		128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479,
		128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
		128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df,
		128'h8ca1890dbfe6426841992d0fb054bb16
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX_TABLE[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] m11 [4];
		logic [7:0] m13 [4];
		logic [7:0] m14 [4];
		logic [31:0] res;
		for (int i = 0; i < 4; i++) begin
			a[i] = w[31 - 8*i -: 8];
			x2[i] = xtime(a[i]);
			x4[i] = xtime(x2[i]);
			x8[i] = xtime(x4[i]);
			m9[i] = x8[i] ^ a[i];
			m11[i] = x8[i] ^ x2[i] ^ a[i];
			m13[i] = x8[i] ^ x4[i] ^ a[i];
			m14[i] = x8[i] ^ x4[i] ^ x2[i];
		end
		res[31:24] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
		res[23:16] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
		res[15:8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
		res[7:0] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
		return res;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/aes128_round_key_expansion.sv */
// aes128_round_key_expansion: AES-128 key schedule, eleven round keys per cipher key
// depends on akx_pkg, akx_round, akx_inv_mix
//
//  channel | signals                                          | dir
//  in      | in_valid, in_ready, key_hi, key_lo, operation    | sink
//  out     | out_valid, out_ready, round_index, round_key_hi, | source
//          | round_key_lo, last                               |
//
// a cipher key is loaded first, then, while out does not stall, one round key
// per cycle goes through the shared round unit and the output register
// in_ready is low from the load until round key 10 has been issued
// a stall on out holds the sequencer, no round key is dropped
// reset clears the sequencer and the output valid, key registers are not reset
`default_nettype none

module aes128_round_key_expansion (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [63:0]   key_hi,
	input  wire logic [63:0]   key_lo,
	input  wire logic          operation,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic      [3:0]    round_index,
	output logic      [63:0]   round_key_hi,
	output logic      [63:0]   round_key_lo,
	output logic               last
);
	import akx_pkg::*;

	logic         busy_q;
	logic [3:0]   round_q;
	logic [127:0] key_q;
	logic [7:0]   rcon_q;
	logic         op_q;
	logic         out_valid_q;
	logic [3:0]   out_idx_q;
	logic [127:0] out_key_q;
	logic         out_last_q;

	logic         accept;
	logic         issue;
	logic         mix_en;
	logic [127:0] key_next;
	logic [127:0] key_view;

	akx_round u_round (
		.key_cur  (key_q),
		.rcon     (rcon_q),
		.key_next (key_next)
	);

	// outer round keys are never transformed
	assign mix_en = op_q && (round_q != 4'd0) && (round_q != LAST_ROUND);

	akx_inv_mix u_inv_mix (
		.key_in  (key_q),
		.enable  (mix_en),
		.key_out (key_view)
	);

	assign in_ready = !busy_q;
	assign accept = in_valid && in_ready;
	assign issue = busy_q && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			round_q <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				round_q <= 4'd0;
			end else if (issue) begin
				round_q <= round_q + 4'd1;
				if (round_q == LAST_ROUND) begin
					busy_q <= 1'b0;
				end
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {key_hi, key_lo};
			op_q <= operation;
			rcon_q <= RCON_FIRST;
		end else if (issue) begin
			key_q <= key_next;
			rcon_q <= xtime(rcon_q);
			out_idx_q <= round_q;
			out_key_q <= key_view;
			out_last_q <= (round_q == LAST_ROUND);
		end
	end

	assign out_valid = out_valid_q;
	assign round_index = out_idx_q;
	assign round_key_hi = out_key_q[127:64];
	assign round_key_lo = out_key_q[63:0];
	assign last = out_last_q;

`ifndef SYNTHESIS
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (round_q <= LAST_ROUND))
		else $error("round counter past the last round key");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && round_q == 4'd0))
		else $error("accepted item did not start at round key 0");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_idx_q == LAST_ROUND)))
		else $error("last flag does not match round index");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && round_q == LAST_ROUND) |=> !busy_q)
		else $error("sequencer still busy after round key 10");
`endif

endmodule

`default_nettype wire

/* hw/rtl/akx_round.sv */
// akx_round: one step of the AES-128 key schedule, round key i to round key i+1
// RotWord, SubWord and Rcon on word 3, then the chained word XORs
// depends on akx_pkg
`default_nettype none

module akx_round (
	input  wire logic [127:0] key_cur,
	input  wire logic [7:0]   rcon,
	output logic      [127:0] key_next
);
	import akx_pkg::*;

	logic [31:0] w0, w1, w2, w3;
	logic [31:0] rot, sub;
	logic [31:0] n0, n1, n2, n3;

	assign w0 = key_cur[127:96];
	assign w1 = key_cur[95:64];
	assign w2 = key_cur[63:32];
	assign w3 = key_cur[31:0];

	assign rot = {w3[23:0], w3[31:24]};
	assign sub = {sbox(rot[31:24]), sbox(rot[23:16]), sbox(rot[15:8]), sbox(rot[7:0])};

	assign n0 = w0 ^ sub ^ {rcon, 24'h000000};
	assign n1 = w1 ^ n0;
	assign n2 = w2 ^ n1;
	assign n3 = w3 ^ n2;

	assign key_next = {n0, n1, n2, n3};

endmodule

`default_nettype wire

/* hw/rtl/akx_inv_mix.sv */
// akx_inv_mix: optional InvMixColumns over the four words of a round key
// used for the equivalent inverse cipher keys
// depends on akx_pkg
`default_nettype none

module akx_inv_mix (
	input  wire logic [127:0] key_in,
	input  wire logic         enable,
	output logic      [127:0] key_out
);
	import akx_pkg::*;

	logic [127:0] mixed;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			mixed[127 - 32*j -: 32] = inv_mix_col(key_in[127 - 32*j -: 32]);
		end
	end

	assign key_out = enable ? mixed : key_in;

endmodule

`default_nettype wire
